// ----- sv/aosd_pkg.sv -----
// Shared types and constants for the alpha overlay / SAD delta block.
// No dependencies; used by every module of the block except aosd_blend.

package aosd_pkg;

    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 88;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;
    localparam int DELTA_W    = 27;
    localparam int POS_W      = 15;

    localparam logic [8:0]  MAX_SHAPE_DIM  = 9'd256;
    localparam logic [12:0] MAX_CANVAS_DIM = 13'd4096;

    localparam logic signed [DELTA_W:0] DELTA_LIMIT     = 28'sd50135040;
    localparam logic signed [DELTA_W:0] DELTA_LIMIT_NEG = -28'sd50135040;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHAPE_WIDTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHAPE_HEIGHT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WRITE_BACK    = 3'd6;

    typedef struct packed {
        logic [12:0]        canvas_width;
        logic [12:0]        canvas_height;
        logic [8:0]         shape_width;
        logic [8:0]         shape_height;
        logic signed [13:0] center_x;
        logic signed [13:0] center_y;
        logic               write_back;
    } cfg_t;

    typedef struct packed {
        logic signed [POS_W-1:0] pixel_x;
        logic signed [POS_W-1:0] pixel_y;
        logic                    in_canvas;
    } place_t;

endpackage

// ----- sv/aosd_blend.sv -----
// One color channel of the source-over blend: round((s*a + d*(255-a)) / 255).
// Depends on nothing; instantiated once per channel by the top level.

module aosd_blend (
    input  logic [7:0] src,
    input  logic [7:0] dst,
    input  logic [7:0] alpha,
    output logic [7:0] blend
);

    logic [15:0] prod_src;
    logic [15:0] prod_dst;
    logic [16:0] num;
    logic [16:0] num_rnd;
    logic [31:0] scaled;

    always_comb
    begin
        prod_src = src * alpha;
        prod_dst = dst * (8'd255 - alpha);
        num      = {1'b0, prod_src} + {1'b0, prod_dst};
        // round half up: floor((n + 127) / 255), n + 127 stays below 2^16
        num_rnd  = num + 17'd127;
        // x / 255 == (x * 0x8081) >> 23 over this range, done as shifts and adds
        scaled   = {num_rnd, 15'd0} + {8'd0, num_rnd, 7'd0} + {15'd0, num_rnd};
        blend    = scaled[30:23];
    end

endmodule

// ----- sv/aosd_place.sv -----
// Maps a shape offset to a canvas position and tests it against the canvas bounds.
// Depends on aosd_pkg for the configuration and position types.

module aosd_place (
    input  aosd_pkg::cfg_t   cfg,
    input  logic [7:0]       offset_x,
    input  logic [7:0]       offset_y,
    output aosd_pkg::place_t place
);

    logic [8:0]  shape_w;
    logic [8:0]  shape_h;
    logic [12:0] canvas_w;
    logic [12:0] canvas_h;
    logic [14:0] pos_x;
    logic [14:0] pos_y;
    logic        in_x;
    logic        in_y;

    always_comb
    begin
        shape_w  = (cfg.shape_width > aosd_pkg::MAX_SHAPE_DIM) ?
                   aosd_pkg::MAX_SHAPE_DIM : cfg.shape_width;
        shape_h  = (cfg.shape_height > aosd_pkg::MAX_SHAPE_DIM) ?
                   aosd_pkg::MAX_SHAPE_DIM : cfg.shape_height;
        canvas_w = (cfg.canvas_width > aosd_pkg::MAX_CANVAS_DIM) ?
                   aosd_pkg::MAX_CANVAS_DIM : cfg.canvas_width;
        canvas_h = (cfg.canvas_height > aosd_pkg::MAX_CANVAS_DIM) ?
                   aosd_pkg::MAX_CANVAS_DIM : cfg.canvas_height;

        pos_x = {cfg.center_x[13], cfg.center_x} - {7'd0, shape_w[8:1]} + {7'd0, offset_x};
        pos_y = {cfg.center_y[13], cfg.center_y} - {7'd0, shape_h[8:1]} + {7'd0, offset_y};

        // a zero canvas dimension leaves nothing inside
        in_x = !pos_x[14] && (pos_x[13:0] < {1'b0, canvas_w});
        in_y = !pos_y[14] && (pos_y[13:0] < {1'b0, canvas_h});

        place.pixel_x   = $signed(pos_x);
        place.pixel_y   = $signed(pos_y);
        place.in_canvas = in_x && in_y;
    end

endmodule

// ----- sv/aosd_delta.sv -----
// Similarity delta: SAD(base,canvas) - SAD(base,blend) added to the running sum,
// saturated at the delta limit. Depends on aosd_pkg for widths and limits.

module aosd_delta (
    input  logic [23:0]                        base_rgb,
    input  logic [7:0]                         canvas_red,
    input  logic [7:0]                         canvas_green,
    input  logic [7:0]                         canvas_blue,
    input  logic [7:0]                         blend_red,
    input  logic [7:0]                         blend_green,
    input  logic [7:0]                         blend_blue,
    input  logic                               in_canvas,
    input  logic signed [aosd_pkg::DELTA_W-1:0] acc_in,
    output logic signed [aosd_pkg::DELTA_W-1:0] acc_out
);

    function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

    logic [9:0]                          sad_before;
    logic [9:0]                          sad_after;
    logic signed [10:0]                  diff;
    logic signed [aosd_pkg::DELTA_W:0]   sum;

    always_comb
    begin
        sad_before = {2'd0, abs_diff(base_rgb[23:16], canvas_red)}
                   + {2'd0, abs_diff(base_rgb[15:8], canvas_green)}
                   + {2'd0, abs_diff(base_rgb[7:0], canvas_blue)};
        sad_after  = {2'd0, abs_diff(base_rgb[23:16], blend_red)}
                   + {2'd0, abs_diff(base_rgb[15:8], blend_green)}
                   + {2'd0, abs_diff(base_rgb[7:0], blend_blue)};
        diff = $signed({1'b0, sad_before}) - $signed({1'b0, sad_after});
        sum  = $signed({acc_in[aosd_pkg::DELTA_W-1], acc_in})
             + $signed({{(aosd_pkg::DELTA_W - 10){diff[10]}}, diff});

        if (!in_canvas)
            acc_out = acc_in;
        else if (sum > aosd_pkg::DELTA_LIMIT)
            acc_out = aosd_pkg::DELTA_LIMIT[aosd_pkg::DELTA_W-1:0];
        else if (sum < aosd_pkg::DELTA_LIMIT_NEG)
            acc_out = aosd_pkg::DELTA_LIMIT_NEG[aosd_pkg::DELTA_W-1:0];
        else
            acc_out = sum[aosd_pkg::DELTA_W-1:0];
    end

endmodule

// ----- sv/alpha_overlay_sad_delta.sv -----
// Alpha overlay with SAD delta, top level: input register, blend/placement stage,
// delta stage and output register. Depends on aosd_pkg, aosd_place, aosd_blend, aosd_delta.
//
// Takes one shape pixel per clock while the output is not stalled and returns
// one result per pixel, in order. The result passes through the input register,
// blend register and output register before it is offered on the output.
// Throughput is one pixel per cycle while m_tready holds; the running delta is
// added and saturated combinationally in the last stage, so back-to-back
// pixels never wait on it. Pixels that map outside the canvas still give a
// result, with zero color, write flag low and the delta unchanged. The result
// marked by tlast carries the run total; the accumulator then restarts at zero. Registers
// are written through cfg_write/cfg_index/cfg_data; the user must do so only while the
// block is empty, which it does not enforce; indexes past the register list are ignored.

module alpha_overlay_sad_delta (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [aosd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [aosd_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // offset_x, offset_y, shape_red, shape_green, shape_blue, shape_alpha,
    // canvas_red, canvas_green, canvas_blue, base_rgb
    input  logic [aosd_pkg::IN_DATA_W-1:0]      s_tdata,
    input  logic                                s_tlast,   // last_pixel
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // blend_red, blend_green, blend_blue, inside_res, write_pixel, pixel_x,
    // pixel_y, delta_sum, 5 zero bits
    output logic [aosd_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                                m_tlast    // run_done
);

    // configuration
    aosd_pkg::cfg_t cfg_reg, cfg_next;

    // input register
    logic                              a_valid_reg, a_valid_next;
    logic [aosd_pkg::IN_DATA_W-1:0]    a_data_reg;
    logic                              a_last_reg;

    // blend register
    logic                              b_valid_reg, b_valid_next;
    logic [7:0]                        b_blend_r_reg, b_blend_g_reg, b_blend_b_reg;
    logic [23:0]                       b_canvas_rgb_reg;
    logic [23:0]                       b_base_rgb_reg;
    aosd_pkg::place_t                  b_place_reg;
    logic                              b_write_reg;
    logic                              b_last_reg;

    // output register
    logic                              o_valid_reg, o_valid_next;
    logic [aosd_pkg::OUT_DATA_W-1:0]   o_data_reg;
    logic                              o_last_reg;

    logic signed [aosd_pkg::DELTA_W-1:0] acc_reg, acc_next;
    logic signed [aosd_pkg::DELTA_W-1:0] acc_upd;

    logic             o_free, b_free, a_free;
    logic             b_adv, a_adv, s_take;
    aosd_pkg::place_t place;
    logic [7:0]       blend_r, blend_g, blend_b;

    assign o_free   = !o_valid_reg || m_tready;
    assign b_adv    = b_valid_reg && o_free;
    assign b_free   = !b_valid_reg || o_free;
    assign a_adv    = a_valid_reg && b_free;
    assign a_free   = !a_valid_reg || b_free;
    assign s_tready = a_free;
    assign s_take   = s_tvalid && a_free;

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = o_data_reg;
    assign m_tlast  = o_last_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                aosd_pkg::REG_CANVAS_WIDTH:  cfg_next.canvas_width  = cfg_data[12:0];
                aosd_pkg::REG_CANVAS_HEIGHT: cfg_next.canvas_height = cfg_data[12:0];
                aosd_pkg::REG_SHAPE_WIDTH:   cfg_next.shape_width   = cfg_data[8:0];
                aosd_pkg::REG_SHAPE_HEIGHT:  cfg_next.shape_height  = cfg_data[8:0];
                aosd_pkg::REG_CENTER_X:      cfg_next.center_x      = $signed(cfg_data);
                aosd_pkg::REG_CENTER_Y:      cfg_next.center_y      = $signed(cfg_data);
                aosd_pkg::REG_WRITE_BACK:    cfg_next.write_back    = cfg_data[0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    aosd_place u_place (
        .cfg      (cfg_reg),
        .offset_x (a_data_reg[7:0]),
        .offset_y (a_data_reg[15:8]),
        .place    (place)
    );

    aosd_blend u_blend_r (
        .src   (a_data_reg[23:16]),
        .dst   (a_data_reg[55:48]),
        .alpha (a_data_reg[47:40]),
        .blend (blend_r)
    );

    aosd_blend u_blend_g (
        .src   (a_data_reg[31:24]),
        .dst   (a_data_reg[63:56]),
        .alpha (a_data_reg[47:40]),
        .blend (blend_g)
    );

    aosd_blend u_blend_b (
        .src   (a_data_reg[39:32]),
        .dst   (a_data_reg[71:64]),
        .alpha (a_data_reg[47:40]),
        .blend (blend_b)
    );

    aosd_delta u_delta (
        .base_rgb     (b_base_rgb_reg),
        .canvas_red   (b_canvas_rgb_reg[23:16]),
        .canvas_green (b_canvas_rgb_reg[15:8]),
        .canvas_blue  (b_canvas_rgb_reg[7:0]),
        .blend_red    (b_blend_r_reg),
        .blend_green  (b_blend_g_reg),
        .blend_blue   (b_blend_b_reg),
        .in_canvas    (b_place_reg.in_canvas),
        .acc_in       (acc_reg),
        .acc_out      (acc_upd)
    );

    always_comb
    begin
        a_valid_next = s_take ? 1'b1 : (a_adv ? 1'b0 : a_valid_reg);
        b_valid_next = a_adv ? 1'b1 : (b_adv ? 1'b0 : b_valid_reg);
        o_valid_next = b_adv ? 1'b1 : (m_tready ? 1'b0 : o_valid_reg);
        acc_next     = acc_reg;
        if (b_adv)
            acc_next = b_last_reg ? '0 : acc_upd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.canvas_width  <= 13'd1024;
            cfg_reg.canvas_height <= 13'd1024;
            cfg_reg.shape_width   <= 9'd256;
            cfg_reg.shape_height  <= 9'd256;
            cfg_reg.center_x      <= '0;
            cfg_reg.center_y      <= '0;
            cfg_reg.write_back    <= 1'b0;
            a_valid_reg           <= 1'b0;
            b_valid_reg           <= 1'b0;
            o_valid_reg           <= 1'b0;
            acc_reg               <= '0;
        end
        else
        begin
            cfg_reg     <= cfg_next;
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            o_valid_reg <= o_valid_next;
            acc_reg     <= acc_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_take)
        begin
            a_data_reg <= s_tdata;
            a_last_reg <= s_tlast;
        end
        if (a_adv)
        begin
            // outside pixels report a zero color
            b_blend_r_reg    <= place.in_canvas ? blend_r : 8'd0;
            b_blend_g_reg    <= place.in_canvas ? blend_g : 8'd0;
            b_blend_b_reg    <= place.in_canvas ? blend_b : 8'd0;
            b_canvas_rgb_reg <= {a_data_reg[55:48], a_data_reg[63:56], a_data_reg[71:64]};
            b_base_rgb_reg   <= a_data_reg[95:72];
            b_place_reg      <= place;
            b_write_reg      <= place.in_canvas && cfg_reg.write_back;
            b_last_reg       <= a_last_reg;
        end
        if (b_adv)
        begin
            o_data_reg <= {5'd0, acc_upd, b_place_reg.pixel_y, b_place_reg.pixel_x,
                           b_write_reg, b_place_reg.in_canvas,
                           b_blend_b_reg, b_blend_g_reg, b_blend_r_reg};
            o_last_reg <= b_last_reg;
        end
    end

endmodule

// ----- sv/aosd_checker.sv -----
// Port-level checks for alpha_overlay_sad_delta, attached by the bind below.
// Depends on aosd_pkg for port widths.

module aosd_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            cfg_write,
    input logic [aosd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [aosd_pkg::CFG_DATA_W-1:0] cfg_data,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [aosd_pkg::IN_DATA_W-1:0]  s_tdata,
    input logic                            s_tlast,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [aosd_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic                            m_tlast
);

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // write flag only for pixels inside the canvas
    a_write_inside: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (!m_tdata[25] || m_tdata[24]))
        else $error("write flagged for an outside pixel");

    // outside pixels report a zero color
    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[24] |-> (m_tdata[23:0] == 24'd0))
        else $error("outside pixel with nonzero color");

    // with nothing waiting at the output the pipeline drains, so input is open
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");

    // running delta stays within the saturation bounds
    a_delta_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[82:56]) <= 27'sd50135040)
                  && ($signed(m_tdata[82:56]) >= -27'sd50135040))
        else $error("delta outside saturation bounds");

endmodule

bind alpha_overlay_sad_delta aosd_checker u_aosd_checker (.*);

// ----- tb/sv/aosd_blend_checker.sv -----
`timescale 1ns / 100ps
// Result checker for alpha_overlay_sad_delta: tracks register writes, predicts
// the blend, placement and running SAD delta of each accepted pixel request and
// compares the output stream field by field. Depends on aosd_pkg.

module aosd_blend_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [aosd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [aosd_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [aosd_pkg::IN_DATA_W-1:0]      s_tdata,
    input  logic                                s_tlast,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [aosd_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  logic                                m_tlast,
    output int                                  fail_count,
    output int                                  pending
);

    typedef struct {
        logic [7:0]                          red;
        logic [7:0]                          green;
        logic [7:0]                          blue;
        logic                                in_canvas;
        logic                                write_pixel;
        logic signed [aosd_pkg::POS_W-1:0]   pixel_x;
        logic signed [aosd_pkg::POS_W-1:0]   pixel_y;
        logic signed [aosd_pkg::DELTA_W-1:0] delta_sum;
        logic                                run_done;
    } blend_result_t;

    aosd_pkg::cfg_t                      cfg;
    logic signed [aosd_pkg::DELTA_W-1:0] delta_acc;
    blend_result_t                       expected_pixels[$];

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    function automatic int blend_channel(input int s, input int d, input int a);
        // round((s*a + d*(255-a)) / 255) in exact integer form
        return (2 * (s * a + d * (255 - a)) + 255) / 510;
    endfunction

    function automatic int channel_diff(input int a, input int b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic blend_result_t predict_blend(
        input logic [aosd_pkg::IN_DATA_W-1:0] d,
        input logic                           last);
        blend_result_t r;
        int sw, sh, cw, ch, px, py, sad_before, sad_after, acc;
        int sa, cr, cg, cb, br, bg, bb;
        sa = int'(d[47:40]);
        cr = int'(d[55:48]);
        cg = int'(d[63:56]);
        cb = int'(d[71:64]);
        br = int'(d[95:88]);
        bg = int'(d[87:80]);
        bb = int'(d[79:72]);
        sw = (cfg.shape_width > aosd_pkg::MAX_SHAPE_DIM) ?
             int'(aosd_pkg::MAX_SHAPE_DIM) : int'(cfg.shape_width);
        sh = (cfg.shape_height > aosd_pkg::MAX_SHAPE_DIM) ?
             int'(aosd_pkg::MAX_SHAPE_DIM) : int'(cfg.shape_height);
        cw = (cfg.canvas_width > aosd_pkg::MAX_CANVAS_DIM) ?
             int'(aosd_pkg::MAX_CANVAS_DIM) : int'(cfg.canvas_width);
        ch = (cfg.canvas_height > aosd_pkg::MAX_CANVAS_DIM) ?
             int'(aosd_pkg::MAX_CANVAS_DIM) : int'(cfg.canvas_height);
        px = int'($signed(cfg.center_x)) - sw / 2 + int'(d[7:0]);
        py = int'($signed(cfg.center_y)) - sh / 2 + int'(d[15:8]);

        r.in_canvas = (px >= 0) && (py >= 0) && (px < cw) && (py < ch);
        r.red       = '0;
        r.green     = '0;
        r.blue      = '0;
        if (r.in_canvas)
        begin
            r.red   = 8'(blend_channel(int'(d[23:16]), cr, sa));
            r.green = 8'(blend_channel(int'(d[31:24]), cg, sa));
            r.blue  = 8'(blend_channel(int'(d[39:32]), cb, sa));
            sad_before = channel_diff(br, cr) + channel_diff(bg, cg)
                       + channel_diff(bb, cb);
            sad_after  = channel_diff(br, int'(r.red)) + channel_diff(bg, int'(r.green))
                       + channel_diff(bb, int'(r.blue));
            acc = int'(delta_acc) + sad_before - sad_after;
            if (acc > int'(aosd_pkg::DELTA_LIMIT))
                acc = int'(aosd_pkg::DELTA_LIMIT);
            if (acc < int'(aosd_pkg::DELTA_LIMIT_NEG))
                acc = int'(aosd_pkg::DELTA_LIMIT_NEG);
            delta_acc = acc[aosd_pkg::DELTA_W-1:0];
        end
        r.write_pixel = r.in_canvas && cfg.write_back;
        r.pixel_x     = px[aosd_pkg::POS_W-1:0];
        r.pixel_y     = py[aosd_pkg::POS_W-1:0];
        r.delta_sum   = delta_acc;
        r.run_done    = last;
        if (last)
            delta_acc = '0;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= 50)
            $display("%0t: mismatch: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    endtask

    task automatic compare_result();
        blend_result_t want;
        if (expected_pixels.size() == 0)
        begin
            report_mismatch($sformatf("result with no request outstanding, data %h", m_tdata));
            return;
        end
        want = expected_pixels.pop_front();
        check_field("blend_red",   int'(m_tdata[7:0]),   int'(want.red));
        check_field("blend_green", int'(m_tdata[15:8]),  int'(want.green));
        check_field("blend_blue",  int'(m_tdata[23:16]), int'(want.blue));
        check_field("inside_res",  int'(m_tdata[24]),    int'(want.in_canvas));
        check_field("write_pixel", int'(m_tdata[25]),    int'(want.write_pixel));
        check_field("pixel_x",     int'($signed(m_tdata[40:26])), int'(want.pixel_x));
        check_field("pixel_y",     int'($signed(m_tdata[55:41])), int'(want.pixel_y));
        check_field("delta_sum",   int'($signed(m_tdata[82:56])), int'(want.delta_sum));
        check_field("run_done",    int'(m_tlast),        int'(want.run_done));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg.canvas_width  = 13'd1024;
            cfg.canvas_height = 13'd1024;
            cfg.shape_width   = 9'd256;
            cfg.shape_height  = 9'd256;
            cfg.center_x      = '0;
            cfg.center_y      = '0;
            cfg.write_back    = 1'b0;
            delta_acc         = '0;
            expected_pixels.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    aosd_pkg::REG_CANVAS_WIDTH:  cfg.canvas_width  = cfg_data[12:0];
                    aosd_pkg::REG_CANVAS_HEIGHT: cfg.canvas_height = cfg_data[12:0];
                    aosd_pkg::REG_SHAPE_WIDTH:   cfg.shape_width   = cfg_data[8:0];
                    aosd_pkg::REG_SHAPE_HEIGHT:  cfg.shape_height  = cfg_data[8:0];
                    aosd_pkg::REG_CENTER_X:      cfg.center_x      = cfg_data[13:0];
                    aosd_pkg::REG_CENTER_Y:      cfg.center_y      = cfg_data[13:0];
                    aosd_pkg::REG_WRITE_BACK:    cfg.write_back    = cfg_data[0];
                    default: ;
                endcase
            end
            // new request first: a result at this edge belongs to an older one
            if (s_tvalid && s_tready)
                expected_pixels.push_back(predict_blend(s_tdata, s_tlast));
            if (m_tvalid && m_tready)
                compare_result();
            pending <= expected_pixels.size();
        end
    end

endmodule

// ----- tb/sv/tb_alpha_overlay_sad_delta.sv -----
`timescale 1ns / 100ps
// Top of the alpha_overlay_sad_delta testbench: clock, reset, register writes,
// pixel stimulus and the verdict. Depends on aosd_pkg, aosd_blend_checker and the DUT.

module tb_alpha_overlay_sad_delta;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            cfg_write = 1'b0;
    logic [aosd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [aosd_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [aosd_pkg::IN_DATA_W-1:0]  s_tdata   = '0;
    logic                            s_tlast   = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [aosd_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                            m_tlast;

    int fail_count;
    int pending;
    int idle_pct = 13;
    bit stuck    = 1'b0;

    always #4 clk = ~clk;

    alpha_overlay_sad_delta dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    aosd_blend_checker blend_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always @(posedge clk)
        m_tready <= ($urandom_range(0, 99) >= idle_pct);

    function automatic logic [aosd_pkg::IN_DATA_W-1:0] pack_pixel(
        input int ox, input int oy,
        input int sr, input int sg,
        input int sb, input int sa,
        input int cr, input int cg,
        input int cb, input int base);
        return {base[23:0], cb[7:0], cg[7:0], cr[7:0], sa[7:0], sb[7:0], sg[7:0],
                sr[7:0], oy[7:0], ox[7:0]};
    endfunction

    function automatic logic [aosd_pkg::IN_DATA_W-1:0] random_pixel(input int sw,
                                                                  input int sh);
        int ox, oy, alpha;
        // mostly offsets within the shape, now and then anywhere
        ox = (sw == 0 || $urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                    : $urandom_range(0, sw - 1);
        oy = (sh == 0 || $urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                    : $urandom_range(0, sh - 1);
        case ($urandom_range(0, 4))
            0:       alpha = 0;
            1:       alpha = 255;
            default: alpha = $urandom_range(0, 255);
        endcase
        return pack_pixel(ox, oy, $urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 255), alpha, $urandom_range(0, 255),
                          $urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 24'hFFFFFF));
    endfunction

    // zero, one, the clamp value, the largest encodable, or a typical size
    function automatic int pick_dim(input int top_val, input int clamp_val, input int typical);
        case ($urandom_range(0, 29))
            0:       return 0;
            1:       return 1;
            2:       return clamp_val;
            3:       return top_val;
            default: return $urandom_range(1, typical);
        endcase
    endfunction

    function automatic int pick_center(input int dim);
        case ($urandom_range(0, 29))
            0:       return -8192;
            1:       return 8191;
            default: return $urandom_range(0, (dim > 4096) ? 4096 : dim);
        endcase
    endfunction

    task automatic write_reg(input logic [aosd_pkg::CFG_IDX_W-1:0] idx, input int val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[aosd_pkg::CFG_DATA_W-1:0];
        @(posedge clk);
    endtask

    task automatic apply_config(input int cw, input int ch, input int sw, input int sh,
                                input int cx, input int cy, input int wb);
        write_reg(aosd_pkg::REG_CANVAS_WIDTH,  cw);
        write_reg(aosd_pkg::REG_CANVAS_HEIGHT, ch);
        write_reg(aosd_pkg::REG_SHAPE_WIDTH,   sw);
        write_reg(aosd_pkg::REG_SHAPE_HEIGHT,  sh);
        write_reg(aosd_pkg::REG_CENTER_X,      cx);
        write_reg(aosd_pkg::REG_CENTER_Y,      cy);
        write_reg(aosd_pkg::REG_WRITE_BACK,    wb);
        cfg_write <= 1'b0;
    endtask

    task automatic send_pixel(input logic [aosd_pkg::IN_DATA_W-1:0] data, input logic last);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // hold requests until every expected result is out, then let the pipe settle
    task automatic drain();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0 && waited < 1000)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending != 0)
            stuck = 1'b1;
        repeat (6) @(posedge clk);
    endtask

    initial
    begin
        int phase, runs, run_len, pixels_sent;
        int cw, ch, sw, sh, cx, cy;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 64x48 canvas, 16x16 shape centered at (20,10): pixel at (12+ox, 2+oy)
        apply_config(64, 48, 16, 16, 20, 10, 1);
        send_pixel(pack_pixel(0, 0, 255, 255, 255, 255, 0, 0, 0, 24'hFFFFFF), 1'b0);
        send_pixel(pack_pixel(1, 0, 255, 255, 255, 0, 12, 200, 99, 0), 1'b0);
        send_pixel(pack_pixel(2, 0, 200, 100, 50, 128, 10, 20, 30, 24'h808080), 1'b0);
        drain();
        send_pixel(pack_pixel(3, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0);
        send_pixel(pack_pixel(255, 255, 255, 255, 255, 255, 255, 255, 255, 24'hFFFFFF),
                   1'b0);
        send_pixel(pack_pixel(51, 0, 17, 34, 51, 200, 240, 120, 60, 24'h123456), 1'b0);
        send_pixel(pack_pixel(52, 0, 17, 34, 51, 200, 240, 120, 60, 24'h123456), 1'b0);
        send_pixel(pack_pixel(0, 45, 90, 180, 45, 77, 3, 250, 128, 24'hA5A5A5), 1'b0);
        send_pixel(pack_pixel(0, 46, 90, 180, 45, 77, 3, 250, 128, 24'hA5A5A5), 1'b0);
        // offset past the shape size still maps into the canvas
        send_pixel(pack_pixel(20, 20, 1, 2, 3, 60, 254, 253, 252, 24'h5A5A5A), 1'b0);
        send_pixel(pack_pixel(4, 4, 127, 128, 129, 1, 200, 50, 0, 24'hFF00FF), 1'b1);
        send_pixel(pack_pixel(5, 5, 127, 128, 129, 254, 200, 50, 0, 24'h00FF00), 1'b1);
        drain();

        // zero shape width, oversized shape height and canvas: edges at x=-1/0, y=-1/0
        apply_config(8191, 4096, 0, 511, -1, 126, 0);
        send_pixel(pack_pixel(0, 2, 9, 9, 9, 255, 0, 0, 0, 24'h0F0F0F), 1'b0);
        send_pixel(pack_pixel(1, 1, 9, 9, 9, 255, 0, 0, 0, 24'h0F0F0F), 1'b0);
        send_pixel(pack_pixel(1, 2, 9, 99, 199, 100, 30, 60, 90, 24'h3C78B4), 1'b0);
        send_pixel(pack_pixel(255, 255, 250, 5, 128, 255, 6, 251, 127, 24'hF0F0F0), 1'b1);
        drain();

        // zero canvas width: nothing lands inside
        apply_config(0, 4096, 1, 1, 0, 0, 1);
        send_pixel(pack_pixel(0, 0, 255, 0, 255, 255, 0, 255, 0, 24'hFF00FF), 1'b1);
        drain();

        // extreme centers
        apply_config(4096, 4096, 256, 256, -8192, 8191, 1);
        send_pixel(pack_pixel(255, 255, 255, 0, 255, 255, 0, 255, 0, 24'hFF00FF), 1'b1);
        drain();

        pixels_sent = 0;
        phase = 0;
        while (pixels_sent < 1950)
        begin
            // a few back-to-back phases with no gaps or stalls on either side
            idle_pct = (phase >= 4 && phase <= 6) ? 0 : 13;
            cw = pick_dim(8191, 4096, 300);
            ch = pick_dim(8191, 4096, 300);
            sw = pick_dim(511, 256, 64);
            sh = pick_dim(511, 256, 64);
            cx = pick_center(cw);
            cy = pick_center(ch);
            apply_config(cw, ch, sw, sh, cx, cy, $urandom_range(0, 1));
            if (sw > 256)
                sw = 256;
            if (sh > 256)
                sh = 256;
            runs = $urandom_range(2, 8);
            for (int r = 0; r < runs; r++)
            begin
                run_len = $urandom_range(1, 40);
                // some runs are left open so the delta carries across a reconfig
                for (int i = 0; i < run_len; i++)
                begin
                    send_pixel(random_pixel(sw, sh),
                               (i == run_len - 1) && ($urandom_range(0, 6) != 0));
                    pixels_sent++;
                end
                if ($urandom_range(0, 9) == 0)
                    drain();
            end
            drain();
            phase++;
        end

        if (fail_count == 0 && !stuck)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #(20_000_000);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
